// ===== rtl/shared_buffer_admission_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shared buffer admission core
// Implication checks on the rising clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SHARED_BUFFER_ADMISSION_CORE_ASSERT_SVH
`define SHARED_BUFFER_ADMISSION_CORE_ASSERT_SVH
`ifndef SYNTH
`define SBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sba: same-cycle check failed");
`define SBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sba: next-cycle check failed");
`else
`define SBA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// Shared buffer admission package
// Request and response records, configuration record, codes and helpers.
// ----------------------------------------------------------------------------
package sba_pkg;

   localparam int BSZ_W     = 24;
   localparam int DIVISOR_W = 7;
   localparam int THR_W     = 40;
   localparam logic [63:0] EMPTY_QLEN = 64'd64;

   typedef enum logic [1:0] {
      OP_ENQUEUE   = 2'd0,
      OP_DEQUEUE   = 2'd1,
      OP_SET_ALPHA = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      MODE_EQUAL     = 3'd0,
      MODE_SHARED    = 3'd1,
      MODE_DYNAMIC   = 3'd2,
      MODE_EDT       = 3'd3,
      MODE_ALPHA     = 3'd4,
      MODE_DEDICATED = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      VERDICT_ADMIT          = 2'd0,
      VERDICT_RING_FULL      = 2'd1,
      VERDICT_DROP_THRESHOLD = 2'd2,
      VERDICT_DROP_OVERFLOW  = 2'd3
   } verdict_type;

   localparam logic [2:0] CSR_THRESHOLD_MODE  = 3'd0;
   localparam logic [2:0] CSR_BUFFER_SIZE     = 3'd1;
   localparam logic [2:0] CSR_PORT_LIMIT      = 3'd2;
   localparam logic [2:0] CSR_ACTIVE_PORTS    = 3'd3;
   localparam logic [2:0] CSR_ALPHA_SHIFT     = 3'd4;
   localparam logic [2:0] CSR_BURST_COUNT     = 3'd5;
   localparam logic [2:0] CSR_BURST_TIME      = 3'd6;
   localparam logic [2:0] CSR_IDLE_TIME       = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FETCH,
      ST_DIVIDE,
      ST_CALC,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [23:0] buffer_size;
      logic [23:0] port_limit;
      logic [5:0]  active_ports;
      logic [2:0]  alpha_shift;
      logic [15:0] burst_count_limit;
      logic [31:0] burst_time_limit;
      logic [31:0] idle_time_limit;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [4:0]  port;
      logic        in_range;
      logic [15:0] len;
      logic        room;
      logic [4:0]  alpha;
      logic [63:0] now;
   } cmd_type;

   typedef struct packed {
      verdict_type verdict;
      logic [23:0] queue;
      logic [23:0] occupancy;
      logic [31:0] threshold;
   } rsp_type;

   typedef struct packed {
      logic [63:0] enq;
      logic [63:0] deq;
   } cnt_type;

   typedef struct packed {
      logic [31:0] burst_count;
      logic [63:0] burst_start;
      logic [63:0] refresh;
   } edt_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [23:0] sat24(input logic [63:0] v);
      return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
   endfunction

   function automatic logic [63:0] qlen(input cnt_type c);
      return (c.enq > c.deq) ? (c.enq - c.deq) : EMPTY_QLEN;
   endfunction

endpackage

// ===== rtl/sba_fifo.sv =====
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples a producer and a consumer; full and empty come from registers.
// ----------------------------------------------------------------------------
module sba_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      do_push   = push & ~full;
      do_pop    = pop & ~empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      pop_data  = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sba_front.sv =====
// ----------------------------------------------------------------------------
// Request front end
// Decodes and range-checks each request and queues it for the engine.
// ----------------------------------------------------------------------------
module sba_front #(
   parameter int MAX_PORTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_opcode,
   input  logic [4:0]        req_port,
   input  logic [15:0]       req_length_bytes,
   input  logic              req_ring_has_room,
   input  logic signed [4:0] req_alpha,
   input  logic [63:0]       req_now_cycles,
   input  logic              cmd_pop,
   output sba_pkg::cmd_type  cmd,
   output logic              cmd_empty
);

   sba_pkg::cmd_type in_cmd;
   logic [$bits(sba_pkg::cmd_type)-1:0] head;

   always_comb begin
      in_cmd.op       = sba_pkg::op_type'(req_opcode);
      in_cmd.port     = req_port;
      in_cmd.in_range = (32'(req_port) < MAX_PORTS);
      in_cmd.len      = req_length_bytes;
      in_cmd.room     = req_ring_has_room;
      in_cmd.alpha    = req_alpha;
      in_cmd.now      = req_now_cycles;
      cmd             = sba_pkg::cmd_type'(head);
   end

   sba_fifo #(.WIDTH($bits(sba_pkg::cmd_type))) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (in_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (head),
      .empty     (cmd_empty)
   );

endmodule

// ===== rtl/sba_divider.sv =====
// ----------------------------------------------------------------------------
// Threshold divider
// Restoring division of the buffer size by a small count, two bits a cycle.
// ----------------------------------------------------------------------------
module sba_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sba_pkg::BSZ_W-1:0]      dividend,
   input  logic [sba_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic [sba_pkg::BSZ_W-1:0]      quotient
);

   localparam int STEPS = sba_pkg::BSZ_W / 2;
   localparam int CW    = $clog2(STEPS + 1);

   logic [sba_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [sba_pkg::BSZ_W-1:0]     quo_ff, quo_in;
   logic [sba_pkg::DIVISOR_W-1:0] div_ff, div_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [sba_pkg::DIVISOR_W:0]   trial;
   logic [sba_pkg::DIVISOR_W-1:0] r;
   logic [sba_pkg::BSZ_W-1:0]     q;

   always_comb begin
      r = rem_ff;
      q = quo_ff;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
         trial = {r, q[sba_pkg::BSZ_W-1]};
         q = {q[sba_pkg::BSZ_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
            q[0] = 1'b1;
         end
         r = trial[sba_pkg::DIVISOR_W-1:0];
      end
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = r;
         quo_in  = q;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
      busy     = busy_ff;
      quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

// ===== rtl/sba_engine.sv =====
// ----------------------------------------------------------------------------
// Admission engine
// Walks the port counters for occupancy, picks the threshold, decides the
// verdict and updates the per-port counters, alpha and burst tracking.
// ----------------------------------------------------------------------------
`include "shared_buffer_admission_core_assert.svh"

module sba_engine #(
   parameter int MAX_PORTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  sba_pkg::cfg_type cfg,
   input  logic             cmd_empty,
   input  sba_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output sba_pkg::rsp_type rsp
);

   localparam int AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
   localparam int IW = $clog2(MAX_PORTS + 1);

   // Storage, cleared by valid bits at reset.
   sba_pkg::cnt_type cnt_mem [MAX_PORTS];
   logic [4:0]       alpha_mem [MAX_PORTS];
   sba_pkg::edt_type edt_mem [MAX_PORTS];
   logic [MAX_PORTS-1:0] cnt_vld_ff, alpha_vld_ff, edt_vld_ff;
   logic [MAX_PORTS-1:0] unc_ff, idle_ff;

   sba_pkg::cnt_type cnt_rd_ff, cnt_q, cnt_wr_data;
   logic [4:0]       alpha_rd_ff, alpha_q;
   sba_pkg::edt_type edt_rd_ff, edt_q, edt_wr_data;
   logic             cnt_rd_vld_ff, alpha_rd_vld_ff, edt_rd_vld_ff;
   logic             cnt_rd_en, side_rd_en, cnt_we, alpha_we, edt_we, flag_we;
   logic [AW-1:0]    cnt_rd_addr, port_addr;

   sba_pkg::state_type state_ff, state_in;
   sba_pkg::cmd_type   cmd_ff, cmd_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in, ucnt_ff, ucnt_in, n_ports;
   logic               d1_ff, d1_in, qv_ff, qv_in;
   logic [63:0]        qlen_ff, qlen_in, occ_ff, occ_in;
   logic [63:0]        q_ff, q_in, qe_ff, qe_in, occ_len_ff, occ_len_in;
   logic [23:0]        free_ff, free_in;
   logic [sba_pkg::THR_W-1:0] thr_ff, thr_in, thr_sel, free_wide;
   sba_pkg::edt_type   edt_new_ff, edt_new_in;
   logic               unc_new_ff, unc_new_in, idle_new_ff, idle_new_in;

   logic                          div_start, div_busy;
   logic [sba_pkg::DIVISOR_W-1:0] div_divisor;
   logic [sba_pkg::BSZ_W-1:0]     div_quotient;

   logic        walk_issue, unc_o, idle_o, over_thr, trig, is_edt;
   logic [31:0] bc_new;
   logic [63:0] len64;
   sba_pkg::verdict_type enq_verdict;

   assign port_addr = AW'(cmd_ff.port);
   assign n_ports   = (32'(cfg.active_ports) > MAX_PORTS) ? IW'(MAX_PORTS)
                                                          : IW'(cfg.active_ports);
   assign len64     = {48'b0, cmd_ff.len};
   assign is_edt    = (cfg.mode == sba_pkg::MODE_EDT);
   assign cnt_q     = cnt_rd_vld_ff ? cnt_rd_ff : '0;
   assign alpha_q   = alpha_rd_vld_ff ? alpha_rd_ff : '0;
   assign edt_q     = edt_rd_vld_ff ? edt_rd_ff : '0;
   assign unc_o     = unc_ff[port_addr];
   assign idle_o    = idle_ff[port_addr];
   assign walk_issue = (rd_idx_ff < n_ports);
   assign free_wide = {16'b0, free_ff};

   sba_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.buffer_size),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      if (cfg.mode == sba_pkg::MODE_EQUAL) begin
         div_divisor = (cfg.active_ports == 6'd0) ? 7'd1 : {1'b0, cfg.active_ports};
      end else begin
         div_divisor = (ucnt_ff == '0) ? 7'd1 : 7'(ucnt_ff);
      end
   end

   // Threshold selection; a negative alpha shifts right by its magnitude.
   always_comb begin
      unique case (sba_pkg::mode_type'(cfg.mode))
         sba_pkg::MODE_EQUAL: thr_sel = {16'b0, div_quotient};
         sba_pkg::MODE_SHARED: thr_sel = {16'b0, cfg.buffer_size};
         sba_pkg::MODE_EDT: begin
            thr_sel = unc_o ? {16'b0, div_quotient} : (free_wide << cfg.alpha_shift);
         end
         sba_pkg::MODE_ALPHA: begin
            if (alpha_q[4]) begin
               thr_sel = free_wide >> (6'd32 - {1'b0, alpha_q});
            end else begin
               thr_sel = free_wide << alpha_q[3:0];
            end
         end
         sba_pkg::MODE_DEDICATED: thr_sel = {16'b0, cfg.port_limit};
         default: thr_sel = free_wide << cfg.alpha_shift;
      endcase
   end

   // Burst tracking terms, from the stored record and the idle flag of the port.
   always_comb begin
      if (idle_o) begin
         bc_new = '0;
      end else if (edt_q.burst_count != '1) begin
         bc_new = edt_q.burst_count + 32'd1;
      end else begin
         bc_new = edt_q.burst_count;
      end
      trig = (bc_new >= {16'b0, cfg.burst_count_limit});
   end

   always_comb begin
      over_thr = (qe_ff > {24'b0, thr_ff});
      if (cfg.mode == sba_pkg::MODE_DEDICATED) begin
         enq_verdict = over_thr ? sba_pkg::VERDICT_DROP_OVERFLOW : sba_pkg::VERDICT_ADMIT;
      end else if (over_thr) begin
         enq_verdict = sba_pkg::VERDICT_DROP_THRESHOLD;
      end else if (occ_len_ff > {40'b0, cfg.buffer_size}) begin
         enq_verdict = sba_pkg::VERDICT_DROP_OVERFLOW;
      end else begin
         enq_verdict = sba_pkg::VERDICT_ADMIT;
      end
      if (enq_verdict == sba_pkg::VERDICT_ADMIT && !cmd_ff.room) begin
         enq_verdict = sba_pkg::VERDICT_RING_FULL;
      end
   end

   always_comb begin
      rsp.occupancy = sba_pkg::sat24(occ_ff);
      rsp.queue     = cmd_ff.in_range ? sba_pkg::sat24(q_ff) : '0;
      rsp.threshold = '0;
      rsp.verdict   = sba_pkg::VERDICT_ADMIT;
      if (!cmd_ff.in_range) begin
         rsp.verdict = sba_pkg::VERDICT_DROP_OVERFLOW;
      end else if (cmd_ff.op == sba_pkg::OP_ENQUEUE) begin
         rsp.verdict   = enq_verdict;
         rsp.threshold = thr_ff[31:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      rd_idx_in   = rd_idx_ff;
      ucnt_in     = ucnt_ff;
      d1_in       = 1'b0;
      qv_in       = d1_ff;
      qlen_in     = sba_pkg::qlen(cnt_q);
      occ_in      = qv_ff ? sba_pkg::sat_add(occ_ff, qlen_ff) : occ_ff;
      q_in        = q_ff;
      free_in     = free_ff;
      thr_in      = thr_ff;
      qe_in       = qe_ff;
      occ_len_in  = occ_len_ff;
      edt_new_in  = edt_new_ff;
      unc_new_in  = unc_new_ff;
      idle_new_in = idle_new_ff;
      cmd_pop     = 1'b0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = port_addr;
      side_rd_en  = 1'b0;
      div_start   = 1'b0;
      rsp_push    = 1'b0;
      cnt_we      = 1'b0;
      cnt_wr_data = cnt_q;
      alpha_we    = 1'b0;
      edt_we      = 1'b0;
      edt_wr_data = edt_q;
      flag_we     = 1'b0;
      unique case (state_ff)
         sba_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               rd_idx_in = '0;
               ucnt_in   = '0;
               occ_in    = '0;
               qv_in     = 1'b0;
               state_in  = sba_pkg::ST_WALK;
            end
         end
         sba_pkg::ST_WALK: begin
            // Three-deep pipe: read, queue length, accumulate.
            if (walk_issue) begin
               cnt_rd_en   = 1'b1;
               cnt_rd_addr = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
               d1_in       = 1'b1;
               ucnt_in     = ucnt_ff + IW'(unc_ff[rd_idx_ff[AW-1:0]]);
            end else if (!d1_ff && !qv_ff) begin
               state_in = sba_pkg::ST_FETCH;
            end
         end
         sba_pkg::ST_FETCH: begin
            cnt_rd_en  = 1'b1;
            side_rd_en = 1'b1;
            div_start  = 1'b1;
            state_in   = sba_pkg::ST_DIVIDE;
         end
         sba_pkg::ST_DIVIDE: begin
            q_in    = sba_pkg::qlen(cnt_q);
            free_in = (occ_ff < {40'b0, cfg.buffer_size}) ? (cfg.buffer_size - occ_ff[23:0])
                                                           : '0;
            if (!div_busy) begin
               state_in = sba_pkg::ST_CALC;
            end
         end
         sba_pkg::ST_CALC: begin
            thr_in      = thr_sel;
            qe_in       = sba_pkg::sat_add(q_ff, len64);
            occ_len_in  = sba_pkg::sat_add(occ_ff, len64);
            unc_new_in  = trig | (unc_o & !((cmd_ff.now - edt_q.burst_start) >
                                            {32'b0, cfg.burst_time_limit}));
            edt_new_in.burst_count = bc_new;
            edt_new_in.burst_start = trig ? cmd_ff.now : edt_q.burst_start;
            if (idle_o || unc_new_in) begin
               edt_new_in.refresh = cmd_ff.now;
               idle_new_in        = unc_new_in;
            end else begin
               edt_new_in.refresh = edt_q.refresh;
               idle_new_in = (cmd_ff.now - edt_q.refresh) > {32'b0, cfg.idle_time_limit};
            end
            state_in = sba_pkg::ST_DECIDE;
         end
         sba_pkg::ST_DECIDE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = sba_pkg::ST_IDLE;
               if (cmd_ff.in_range) begin
                  case (cmd_ff.op)
                     sba_pkg::OP_DEQUEUE: begin
                        cnt_we          = 1'b1;
                        cnt_wr_data.deq = cnt_q.deq + len64;
                     end
                     sba_pkg::OP_SET_ALPHA: alpha_we = 1'b1;
                     sba_pkg::OP_ENQUEUE: begin
                        if (enq_verdict == sba_pkg::VERDICT_ADMIT) begin
                           cnt_we          = 1'b1;
                           cnt_wr_data.enq = cnt_q.enq + len64;
                           if (is_edt) begin
                              edt_we      = 1'b1;
                              edt_wr_data = edt_new_ff;
                              flag_we     = 1'b1;
                           end
                        end else if (enq_verdict != sba_pkg::VERDICT_RING_FULL && is_edt) begin
                           edt_we                  = 1'b1;
                           edt_wr_data.burst_count = '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: state_in = sba_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sba_pkg::ST_IDLE;
         d1_ff        <= 1'b0;
         qv_ff        <= 1'b0;
         cnt_vld_ff   <= '0;
         alpha_vld_ff <= '0;
         edt_vld_ff   <= '0;
         unc_ff       <= '0;
         idle_ff      <= '0;
      end else begin
         state_ff <= state_in;
         d1_ff    <= d1_in;
         qv_ff    <= qv_in;
         if (cnt_we) begin
            cnt_vld_ff[port_addr] <= 1'b1;
         end
         if (alpha_we) begin
            alpha_vld_ff[port_addr] <= 1'b1;
         end
         if (edt_we) begin
            edt_vld_ff[port_addr] <= 1'b1;
         end
         if (flag_we) begin
            unc_ff[port_addr]  <= unc_new_ff;
            idle_ff[port_addr] <= idle_new_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rd_idx_ff   <= rd_idx_in;
      ucnt_ff     <= ucnt_in;
      qlen_ff     <= qlen_in;
      occ_ff      <= occ_in;
      q_ff        <= q_in;
      free_ff     <= free_in;
      thr_ff      <= thr_in;
      qe_ff       <= qe_in;
      occ_len_ff  <= occ_len_in;
      edt_new_ff  <= edt_new_in;
      unc_new_ff  <= unc_new_in;
      idle_new_ff <= idle_new_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[port_addr] <= cnt_wr_data;
      end
      if (cnt_rd_en) begin
         cnt_rd_ff     <= cnt_mem[cnt_rd_addr];
         cnt_rd_vld_ff <= cnt_vld_ff[cnt_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (alpha_we) begin
         alpha_mem[port_addr] <= cmd_ff.alpha;
      end
      if (side_rd_en) begin
         alpha_rd_ff     <= alpha_mem[port_addr];
         alpha_rd_vld_ff <= alpha_vld_ff[port_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (edt_we) begin
         edt_mem[port_addr] <= edt_wr_data;
      end
      if (side_rd_en) begin
         edt_rd_ff     <= edt_mem[port_addr];
         edt_rd_vld_ff <= edt_vld_ff[port_addr];
      end
   end

   `SBA_ASSERT_IMPLY(a_push_in_decide, clock, reset, rsp_push, state_ff == sba_pkg::ST_DECIDE && !rsp_full)
   `SBA_ASSERT_IMPLY(a_write_in_decide, clock, reset, cnt_we || edt_we || alpha_we, state_ff == sba_pkg::ST_DECIDE && cmd_ff.in_range)
   `SBA_ASSERT_NEXT(a_take_starts_walk, clock, reset, state_ff == sba_pkg::ST_IDLE && !cmd_empty, state_ff == sba_pkg::ST_WALK)
   `SBA_ASSERT_IMPLY(a_walk_bound, clock, reset, state_ff == sba_pkg::ST_WALK, rd_idx_ff <= n_ports)

endmodule

// ===== rtl/shared_buffer_admission_core.sv =====
// ----------------------------------------------------------------------------
// Shared buffer admission core
// Output-queue admission control over a shared packet buffer.
// ----------------------------------------------------------------------------
// Each request (enqueue, dequeue, set alpha or no-op) yields exactly one response.
// For each request the engine reads the byte counters of every active port,
// one port a cycle through a single memory read port, to sum the buffer
// occupancy and count uncontrolled ports, then runs the divider for the
// equal-division and burst thresholds. Requests are handled one at a time; a
// two-entry queue on each side lets new requests and waiting responses sit
// while the engine works. Port state is cleared by reset at once, so no
// clearing pass is needed.
module shared_buffer_admission_core #(
   parameter int MAX_PORTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_opcode,
   input  logic [4:0]        req_port,
   input  logic [15:0]       req_length_bytes,
   input  logic              req_ring_has_room,
   input  logic signed [4:0] req_alpha,
   input  logic [63:0]       req_now_cycles,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_verdict,
   output logic [23:0]       rsp_queue_bytes,
   output logic [23:0]       rsp_occupancy_bytes,
   output logic [31:0]       rsp_threshold_bytes
);

   sba_pkg::cfg_type cfg_ff, cfg_in;
   sba_pkg::cmd_type cmd;
   sba_pkg::rsp_type rsp, rsp_head;
   logic             cmd_empty, cmd_pop, rsp_full, rsp_push;
   logic [$bits(sba_pkg::rsp_type)-1:0] rsp_bits;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            sba_pkg::CSR_THRESHOLD_MODE: cfg_in.mode              = csr_wdata[2:0];
            sba_pkg::CSR_BUFFER_SIZE:    cfg_in.buffer_size       = csr_wdata[23:0];
            sba_pkg::CSR_PORT_LIMIT:     cfg_in.port_limit        = csr_wdata[23:0];
            sba_pkg::CSR_ACTIVE_PORTS:   cfg_in.active_ports      = csr_wdata[5:0];
            sba_pkg::CSR_ALPHA_SHIFT:    cfg_in.alpha_shift       = csr_wdata[2:0];
            sba_pkg::CSR_BURST_COUNT:    cfg_in.burst_count_limit = csr_wdata[15:0];
            sba_pkg::CSR_BURST_TIME:     cfg_in.burst_time_limit  = csr_wdata;
            sba_pkg::CSR_IDLE_TIME:      cfg_in.idle_time_limit   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode              <= sba_pkg::MODE_DYNAMIC;
         cfg_ff.buffer_size       <= 24'd1048576;
         cfg_ff.port_limit        <= 24'd65536;
         cfg_ff.active_ports      <= 6'd4;
         cfg_ff.alpha_shift       <= 3'd0;
         cfg_ff.burst_count_limit <= 16'd8;
         cfg_ff.burst_time_limit  <= 32'd100000;
         cfg_ff.idle_time_limit   <= 32'd10000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sba_front #(.MAX_PORTS(MAX_PORTS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_port          (req_port),
      .req_length_bytes  (req_length_bytes),
      .req_ring_has_room (req_ring_has_room),
      .req_alpha         (req_alpha),
      .req_now_cycles    (req_now_cycles),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd),
      .cmd_empty         (cmd_empty)
   );

   sba_engine #(.MAX_PORTS(MAX_PORTS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   sba_fifo #(.WIDTH($bits(sba_pkg::rsp_type))) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   always_comb begin
      rsp_head            = sba_pkg::rsp_type'(rsp_bits);
      rsp_verdict         = rsp_head.verdict;
      rsp_queue_bytes     = rsp_head.queue;
      rsp_occupancy_bytes = rsp_head.occupancy;
      rsp_threshold_bytes = rsp_head.threshold;
   end

endmodule
